// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the design files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/qoi_pkg.sv =====
// ---------------------------------------------------------------------------
// qoi_pkg
// shared types, constants and helper functions of the orientation integrator
// ---------------------------------------------------------------------------
package qoi_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int DATA_W        = 16;
	localparam int MUL_W         = 32;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int TAG_W         = 5;

	// multiplier result tags
	localparam logic [TAG_W-1:0] TAG_PROD = 5'd0;
	localparam logic [TAG_W-1:0] TAG_SQR  = 5'd16;
	localparam logic [TAG_W-1:0] TAG_MAT  = 5'd20;

	typedef enum logic [1:0] {
		OP_SQRT = 2'b01,
		OP_DIV  = 2'b10
	} sd_op_t;

	typedef struct packed {
		logic   start;
		sd_op_t op;
	} sd_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sd_rsp_t;

	// sign of term j in product component i
	function automatic logic prod_neg(input logic [1:0] i, input logic [1:0] j);
		prod_neg = (i == 2'd0 && j != 2'd0) || (i == 2'd1 && j == 2'd3) ||
			(i == 2'd2 && j == 2'd1) || (i == 2'd3 && j == 2'd2);
	endfunction

	// operand pairs of the nine matrix products: xx yy zz xy xz yz wx wy wz
	function automatic logic [1:0] mat_a(input logic [3:0] k);
		case (k)
			4'd0: mat_a = 2'd1;
			4'd1: mat_a = 2'd2;
			4'd2: mat_a = 2'd3;
			4'd3: mat_a = 2'd1;
			4'd4: mat_a = 2'd1;
			4'd5: mat_a = 2'd2;
			default: mat_a = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] mat_b(input logic [3:0] k);
		case (k)
			4'd0: mat_b = 2'd1;
			4'd1: mat_b = 2'd2;
			4'd2: mat_b = 2'd3;
			4'd3: mat_b = 2'd2;
			4'd4: mat_b = 2'd3;
			4'd5: mat_b = 2'd3;
			4'd6: mat_b = 2'd1;
			4'd7: mat_b = 2'd2;
			default: mat_b = 2'd3;
		endcase
	endfunction

	// round to frac bits toward minus infinity after half add, then saturate
	function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [63:0] v,
		input int frac);
		logic signed [63:0] t;
		t = (v + (64'sd1 <<< (frac - 1))) >>> frac;
		if (t > 64'sd32767)
			round_sat = 16'sh7fff;
		else if (t < -64'sd32768)
			round_sat = 16'sh8000;
		else
			round_sat = t[DATA_W-1:0];
	endfunction

endpackage

// ===== design/qoi_mul.sv =====
// ---------------------------------------------------------------------------
// qoi_mul
// shared signed multiplier with registered product and result tag
// ---------------------------------------------------------------------------
module qoi_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic [qoi_pkg::TAG_W-1:0]            tag,
	input  logic signed [qoi_pkg::MUL_W-1:0]     a,
	input  logic signed [qoi_pkg::MUL_W-1:0]     b,
	output logic                                 vld_s1,
	output logic [qoi_pkg::TAG_W-1:0]            tag_s1,
	output logic signed [qoi_pkg::PROD_W-1:0]    prod_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			tag_s1  <= tag;
			prod_s1 <= a * b;
		end
	end

endmodule

// ===== design/qoi_sqdiv.sv =====
// ---------------------------------------------------------------------------
// qoi_sqdiv
// bit-serial square root and long division on one shared compare-subtract
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qoi_sqdiv #(
	parameter int FRAC_BITS = qoi_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qoi_pkg::sd_req_t      req,
	input  logic [63:0]           a,
	input  logic [31:0]           b,
	output qoi_pkg::sd_rsp_t      rsp,
	output logic [31:0]           result
);

	localparam int QW       = FRAC_BITS + 1;
	localparam int SQ_STEPS = 32;

	logic             busy_q;
	logic             done_q;
	qoi_pkg::sd_op_t  op_q;
	logic [5:0]       cnt_q;
	logic [5:0]       last;
	logic [63:0]      rem_q;
	logic [63:0]      res_q;
	logic [63:0]      bit_q;
	logic [31:0]      lo_q;
	logic [31:0]      div_q;
	logic [63:0]      ca;
	logic [63:0]      cb;
	logic [63:0]      diff;
	logic             ge;

	// shared compare and subtract
	always_comb begin
		if (op_q == qoi_pkg::OP_SQRT) begin
			ca = rem_q;
			cb = res_q + bit_q;
		end else begin
			ca = {31'd0, rem_q[31:0], lo_q[31]};
			cb = {32'd0, div_q};
		end
		diff = ca - cb;
		ge   = (ca >= cb);
		last = (op_q == qoi_pkg::OP_SQRT) ? 6'(SQ_STEPS - 1) : 6'(QW - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= qoi_pkg::OP_SQRT;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			div_q <= b;
			if (req.op == qoi_pkg::OP_SQRT) begin
				rem_q <= a;
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end else begin
				rem_q <= {32'd0, a[QW+31:QW]};
				res_q <= '0;
				lo_q  <= 32'(a[QW-1:0]) << (32 - QW);
			end
		end else if (busy_q) begin
			if (op_q == qoi_pkg::OP_SQRT) begin
				if (ge) begin
					rem_q <= diff;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				rem_q <= ge ? {32'd0, diff[31:0]} : {32'd0, ca[31:0]};
				res_q <= {res_q[62:0], ge};
				lo_q  <= lo_q << 1;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign result   = res_q[31:0];

	`ASSERT_CLK(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q), "done without a run")
	`ASSERT_NEVER(a_no_restart, clk, arst_n, busy_q && done_q, "unit busy while done")

endmodule

// ===== design/quaternion_orientation_integrator_unit.sv =====
// ---------------------------------------------------------------------------
// quaternion orientation integrator
// pre-multiplies a stored unit quaternion by delta beats and emits its matrix
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one delta quaternion per beat
//   (delta_w, delta_x, delta_y, delta_z, signed fixed point)
//   output channel: out_valid / out_stall carry the nine rotation matrix
//   entries of the updated orientation plus zero_norm
//   one input beat gives exactly one output beat
//   steps in order: products, max search, scaling one bit a step, squares,
//   bit-serial root, one division per component, matrix products, output
//   register; a zero product goes from the max search straight to the
//   matrix products
//   a new item is taken only after the previous one has left the sequencer;
//   the bit-serial root and divider take most of the time per item
//   in_stall is high while an item is in flight or a finished result waits
//   in the sequencer
//   a finished result waits in the output register while out_stall is high;
//   the next item is taken meanwhile and its result waits in the sequencer
//   reset sets the orientation to identity and empties the output register
//   a zero product keeps the orientation and raises zero_norm
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_orientation_integrator_unit #(
	parameter int FRAC_BITS = qoi_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] delta_w,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic signed [15:0] delta_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] m00,
	output logic signed [15:0] m10,
	output logic signed [15:0] m20,
	output logic signed [15:0] m01,
	output logic signed [15:0] m11,
	output logic signed [15:0] m21,
	output logic signed [15:0] m02,
	output logic signed [15:0] m12,
	output logic signed [15:0] m22,
	output logic               zero_norm
);

	// one in q format, saturated when the fraction leaves no integer bit
	localparam logic signed [15:0] ONE_Q = (FRAC_BITS >= 15) ? 16'sh7fff :
		16'(1 << FRAC_BITS);
	localparam logic [35:0] M_HI = 36'd1 << 30;
	localparam logic [35:0] M_LO = 36'd1 << 29;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PROD = 8'b0000_0010,
		ST_MAX  = 8'b0000_0100,
		ST_NORM = 8'b0000_1000,
		ST_SQR  = 8'b0001_0000,
		ST_ROOT = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_MAT  = 8'b1000_0000
	} state_t;

	state_t                  st_q;
	logic [4:0]              cnt_q;
	logic                    go_q;
	logic                    pend_q;
	logic signed [15:0]      d_q [4];
	logic signed [15:0]      q_q [4];
	logic signed [35:0]      p_q [4];
	logic [35:0]             m_q;
	logic [63:0]             sum_q;
	logic [31:0]             r_q;
	logic signed [31:0]      mp_q [9];
	logic                    zero_q;
	logic                    out_valid_q;
	logic signed [15:0]      mat_q [9];
	logic                    zero_norm_q;

	// multiplier port
	logic                               mul_go;
	logic [qoi_pkg::TAG_W-1:0]          mul_tag;
	logic signed [qoi_pkg::MUL_W-1:0]   mul_a;
	logic signed [qoi_pkg::MUL_W-1:0]   mul_b;
	logic                               mul_vld_s1;
	logic [qoi_pkg::TAG_W-1:0]          mul_tag_s1;
	logic signed [qoi_pkg::PROD_W-1:0]  mul_prod_s1;

	// root and divide unit port
	qoi_pkg::sd_req_t  sd_req;
	qoi_pkg::sd_rsp_t  sd_rsp;
	logic [63:0]       sd_a;
	logic [31:0]       sd_res;

	logic [35:0]       pmag [4];
	logic [35:0]       mmax;
	logic              out_free;
	logic              take;
	logic              mul_phase;
	logic              sd_phase;
	logic signed [63:0] mat_v [9];

	function automatic logic [35:0] mag36(input logic signed [35:0] v);
		mag36 = v[35] ? 36'(-v) : 36'(v);
	endfunction

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pmag[i] = mag36(p_q[i]);
		end
		mmax = pmag[0];
		for (int i = 1; i < 4; i++) begin
			if (pmag[i] > mmax)
				mmax = pmag[i];
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_go  = 1'b0;
		mul_tag = qoi_pkg::TAG_PROD;
		mul_a   = '0;
		mul_b   = '0;
		case (st_q)
			ST_PROD: begin
				mul_go  = (cnt_q < 5'd16);
				mul_tag = qoi_pkg::TAG_PROD + cnt_q;
				mul_a   = 32'(d_q[cnt_q[1:0]]);
				mul_b   = 32'(q_q[cnt_q[3:2] ^ cnt_q[1:0]]);
			end
			ST_SQR: begin
				mul_go  = (cnt_q < 5'd4);
				mul_tag = qoi_pkg::TAG_SQR + cnt_q;
				mul_a   = pmag[cnt_q[1:0]][31:0];
				mul_b   = pmag[cnt_q[1:0]][31:0];
			end
			ST_MAT: begin
				mul_go  = (cnt_q < 5'd9);
				mul_tag = qoi_pkg::TAG_MAT + cnt_q;
				mul_a   = 32'(q_q[qoi_pkg::mat_a(cnt_q[3:0])]);
				mul_b   = 32'(q_q[qoi_pkg::mat_b(cnt_q[3:0])]);
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	qoi_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (mul_go),
		.tag     (mul_tag),
		.a       (mul_a),
		.b       (mul_b),
		.vld_s1  (mul_vld_s1),
		.tag_s1  (mul_tag_s1),
		.prod_s1 (mul_prod_s1)
	);

	// root of the sum of squares, then each component over the root with rounding
	always_comb begin
		sd_req.start = 1'b0;
		sd_req.op    = qoi_pkg::OP_SQRT;
		sd_a         = sum_q;
		if (st_q == ST_ROOT) begin
			sd_req.start = !go_q;
		end else if (st_q == ST_DIV) begin
			sd_req.start = !go_q;
			sd_req.op    = qoi_pkg::OP_DIV;
			sd_a         = (64'(pmag[cnt_q[1:0]][31:0]) << FRAC_BITS) + 64'(r_q >> 1);
		end
	end

	qoi_sqdiv #(
		.FRAC_BITS (FRAC_BITS)
	) u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sd_req),
		.a      (sd_a),
		.b      (r_q),
		.rsp    (sd_rsp),
		.result (sd_res)
	);

	// matrix entries with 2*FRAC_BITS fraction bits
	always_comb begin
		logic signed [63:0] one;
		logic signed [63:0] pr [9];
		one = 64'sd1 <<< (2 * FRAC_BITS);
		for (int k = 0; k < 9; k++) begin
			pr[k] = 64'(mp_q[k]);
		end
		// order: xx yy zz xy xz yz wx wy wz
		mat_v[0] = one - 2 * (pr[1] + pr[2]);
		mat_v[1] = 2 * (pr[3] + pr[8]);
		mat_v[2] = 2 * (pr[4] - pr[7]);
		mat_v[3] = 2 * (pr[3] - pr[8]);
		mat_v[4] = one - 2 * (pr[0] + pr[2]);
		mat_v[5] = 2 * (pr[5] + pr[6]);
		mat_v[6] = 2 * (pr[4] + pr[7]);
		mat_v[7] = 2 * (pr[5] - pr[6]);
		mat_v[8] = one - 2 * (pr[0] + pr[1]);
	end

	assign out_free = !out_valid_q || !out_stall;
	// a new item only once the previous result has left the sequencer
	assign take     = (st_q == ST_IDLE) && !pend_q && in_valid;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			go_q        <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			q_q[0]      <= ONE_Q;
			q_q[1]      <= '0;
			q_q[2]      <= '0;
			q_q[3]      <= '0;
		end else begin
			// finished result moves into the output register, else the held beat leaves
			if (pend_q && out_free) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (take) begin
						st_q  <= ST_PROD;
						cnt_q <= '0;
					end
				end
				ST_PROD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16)
						st_q <= ST_MAX;
				end
				ST_MAX: begin
					cnt_q <= '0;
					st_q  <= (mmax == '0) ? ST_MAT : ST_NORM;
				end
				ST_NORM: begin
					if (m_q < M_HI && m_q >= M_LO) begin
						st_q  <= ST_SQR;
						cnt_q <= '0;
					end
				end
				ST_SQR: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd4)
						st_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (sd_rsp.done) begin
						go_q  <= 1'b0;
						cnt_q <= '0;
						st_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (sd_rsp.done) begin
						go_q <= 1'b0;
						// saturate the quotient with the component sign
						if (p_q[cnt_q[1:0]][35]) begin
							q_q[cnt_q[1:0]] <= (sd_res >= 32'd32768) ? 16'sh8000 :
								16'(-$signed(sd_res[16:0]));
						end else begin
							q_q[cnt_q[1:0]] <= (sd_res > 32'd32767) ? 16'sh7fff :
								16'(sd_res[15:0]);
						end
						if (cnt_q == 5'd3) begin
							cnt_q <= '0;
							st_q  <= ST_MAT;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_MAT: begin
					if (cnt_q < 5'd9) begin
						cnt_q <= cnt_q + 5'd1;
					end else if (!pend_q) begin
						pend_q <= 1'b1;
						st_q   <= ST_IDLE;
						cnt_q  <= '0;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			d_q[0] <= delta_w;
			d_q[1] <= delta_x;
			d_q[2] <= delta_y;
			d_q[3] <= delta_z;
		end
		if (st_q == ST_MAX) begin
			m_q    <= mmax;
			zero_q <= (mmax == '0);
			sum_q  <= '0;
		end
		// scale one bit a step until the largest term sits in [2^29, 2^30)
		if (st_q == ST_NORM) begin
			if (m_q >= M_HI) begin
				m_q <= m_q >> 1;
				for (int i = 0; i < 4; i++) begin
					p_q[i] <= p_q[i] >>> 1;
				end
			end else if (m_q < M_LO) begin
				m_q <= m_q << 1;
				for (int i = 0; i < 4; i++) begin
					p_q[i] <= p_q[i] <<< 1;
				end
			end
		end
		if (st_q == ST_ROOT && go_q && sd_rsp.done)
			r_q <= sd_res;
		// multiplier results by tag
		if (mul_vld_s1) begin
			case (mul_tag_s1) inside
				[qoi_pkg::TAG_PROD:qoi_pkg::TAG_SQR - 5'd1]: begin
					if (mul_tag_s1[1:0] == 2'd0) begin
						p_q[mul_tag_s1[3:2]] <= qoi_pkg::prod_neg(mul_tag_s1[3:2],
							mul_tag_s1[1:0]) ? -mul_prod_s1[35:0] : mul_prod_s1[35:0];
					end else begin
						p_q[mul_tag_s1[3:2]] <= p_q[mul_tag_s1[3:2]] +
							(qoi_pkg::prod_neg(mul_tag_s1[3:2], mul_tag_s1[1:0]) ?
							-mul_prod_s1[35:0] : mul_prod_s1[35:0]);
					end
				end
				[qoi_pkg::TAG_SQR:qoi_pkg::TAG_MAT - 5'd1]: begin
					sum_q <= sum_q + mul_prod_s1;
				end
				default: begin
					mp_q[4'(mul_tag_s1 - qoi_pkg::TAG_MAT)] <= mul_prod_s1[31:0];
				end
			endcase
		end
		if (pend_q && out_free) begin
			for (int k = 0; k < 9; k++) begin
				mat_q[k] <= qoi_pkg::round_sat(mat_v[k], FRAC_BITS);
			end
			zero_norm_q <= zero_q;
		end
	end

	assign in_stall  = (st_q != ST_IDLE) || pend_q;
	assign out_valid = out_valid_q;
	assign m00       = mat_q[0];
	assign m10       = mat_q[1];
	assign m20       = mat_q[2];
	assign m01       = mat_q[3];
	assign m11       = mat_q[4];
	assign m21       = mat_q[5];
	assign m02       = mat_q[6];
	assign m12       = mat_q[7];
	assign m22       = mat_q[8];
	assign zero_norm = zero_norm_q;

	assign mul_phase = (st_q == ST_PROD) || (st_q == ST_SQR) || (st_q == ST_MAT);
	assign sd_phase  = (st_q == ST_ROOT) || (st_q == ST_DIV);

	`ASSERT_CLK(a_mul_phase, clk, arst_n, mul_vld_s1 |-> mul_phase, "product outside its phase")
	`ASSERT_CLK(a_sd_phase, clk, arst_n, sd_rsp.done |-> sd_phase, "root unit done out of phase")
	`ASSERT_CLK(a_pend_moves, clk, arst_n, (pend_q && out_free) |=> out_valid_q, "result not out")
	`ASSERT_NEVER(a_root_nonzero, clk, arst_n, st_q == ST_DIV && r_q == '0, "zero root")

endmodule

// ===== dv/qoi_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// orientation integrator checker
// watches both channels, predicts each matrix beat and compares field by field
// ---------------------------------------------------------------------------
module qoi_checker #(
	parameter int FRAC_BITS = qoi_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] delta_w,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic signed [15:0] delta_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] m00,
	input  logic signed [15:0] m10,
	input  logic signed [15:0] m20,
	input  logic signed [15:0] m01,
	input  logic signed [15:0] m11,
	input  logic signed [15:0] m21,
	input  logic signed [15:0] m02,
	input  logic signed [15:0] m12,
	input  logic signed [15:0] m22,
	input  logic               zero_norm,
	output int                 errors,
	output int                 pending,
	output int                 zero_seen
);

	typedef struct {
		logic signed [15:0] ent[9];
		logic               zn;
	} matrix_beat_t;

	logic signed [15:0] quat[4];
	matrix_beat_t       matrix_q[$];

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// advance the orientation by one delta and form the matrix of the result
	function automatic matrix_beat_t rotate(input logic signed [15:0] d[4]);
		matrix_beat_t      b;
		longint            p[4], q[4], w, x, y, z, one, mat[9];
		longint unsigned   mx, a, sum, r, qv;
		int                rs, ls;
		for (int i = 0; i < 4; i++) q[i] = quat[i];
		p[0] = d[0]*q[0] - d[1]*q[1] - d[2]*q[2] - d[3]*q[3];
		p[1] = d[0]*q[1] + d[1]*q[0] + d[2]*q[3] - d[3]*q[2];
		p[2] = d[0]*q[2] - d[1]*q[3] + d[2]*q[0] + d[3]*q[1];
		p[3] = d[0]*q[3] + d[1]*q[2] - d[2]*q[1] + d[3]*q[0];
		mx = 0;
		for (int i = 0; i < 4; i++) begin
			a = (p[i] < 0) ? -p[i] : p[i];
			if (a > mx) mx = a;
		end
		b.zn = (mx == 0);
		if (!b.zn) begin
			rs  = 0;
			ls  = 0;
			sum = 0;
			while ((mx >> rs) >= (64'd1 << 30)) rs++;
			while ((mx << ls) < (64'd1 << 29)) ls++;
			for (int i = 0; i < 4; i++) begin
				p[i] = (rs > 0) ? (p[i] >>> rs) : (p[i] <<< ls);
				a    = (p[i] < 0) ? -p[i] : p[i];
				sum += a * a;
			end
			r = root_floor(sum);
			for (int i = 0; i < 4; i++) begin
				a  = (p[i] < 0) ? -p[i] : p[i];
				qv = ((a << FRAC_BITS) + (r >> 1)) / r;
				if (qv > 40000) qv = 40000;
				quat[i] = clamp16((p[i] < 0) ? -longint'(qv) : longint'(qv));
			end
		end
		w = quat[0]; x = quat[1]; y = quat[2]; z = quat[3];
		one    = 64'sd1 <<< (2 * FRAC_BITS);
		mat[0] = one - 2 * (y*y + z*z);
		mat[1] = 2 * (x*y + w*z);
		mat[2] = 2 * (x*z - w*y);
		mat[3] = 2 * (x*y - w*z);
		mat[4] = one - 2 * (x*x + z*z);
		mat[5] = 2 * (y*z + w*x);
		mat[6] = 2 * (x*z + w*y);
		mat[7] = 2 * (y*z - w*x);
		mat[8] = one - 2 * (x*x + y*y);
		for (int i = 0; i < 9; i++)
			b.ent[i] = clamp16((mat[i] + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] d[4];
		logic signed [15:0] got[9];
		matrix_beat_t       exp_b;
		if (!arst_n) begin
			quat[0]   = clamp16(64'sd1 <<< FRAC_BITS);
			quat[1]   = 0;
			quat[2]   = 0;
			quat[3]   = 0;
			errors    = 0;
			zero_seen = 0;
			matrix_q.delete();
			pending   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				d = '{delta_w, delta_x, delta_y, delta_z};
				matrix_q.push_back(rotate(d));
			end
			if (out_valid && !out_stall) begin
				got = '{m00, m10, m20, m01, m11, m21, m02, m12, m22};
				if (matrix_q.size() == 0) begin
					$display("%0t: matrix beat with nothing expected", $time);
					errors++;
				end else begin
					exp_b = matrix_q.pop_front();
					for (int i = 0; i < 9; i++)
						if (got[i] !== exp_b.ent[i]) begin
							$display("%0t: entry %0d expected %0d actual %0d",
								$time, i, exp_b.ent[i], got[i]);
							errors++;
						end
					if (zero_norm !== exp_b.zn) begin
						$display("%0t: zero_norm expected %0b actual %0b",
							$time, exp_b.zn, zero_norm);
						errors++;
					end
					if (exp_b.zn) zero_seen++;
				end
			end
			pending = matrix_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// orientation integrator testbench
// drives delta quaternion beats with random gaps and output stalls; a
// checker beside the block predicts every matrix beat
// ---------------------------------------------------------------------------
module tb;

	localparam int N_RANDOM  = 1400;
	localparam int WD_LIMIT  = 3000;  // idle cycles before the watchdog fails the run
	localparam int HOLD_LEN  = 800;   // long receiver hold-off
	localparam int HOLD_BEAT = 300;   // output beat before which it happens

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] delta_w, delta_x, delta_y, delta_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
	logic               zero_norm;
	int                 errors, pending, zero_seen;
	int                 sent;
	int                 idle_cycles;

	quaternion_orientation_integrator_unit i_dut (.*);

	qoi_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one delta beat: random gap, then hold until taken
	task automatic send_delta(input logic signed [15:0] w, x, y, z);
		int gap;
		// every third block of 100 beats runs back to back
		gap = ((sent / 100) % 3 == 0) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		delta_w  = w;
		delta_x  = x;
		delta_y  = y;
		delta_z  = z;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] small_val(input int span);
		return 16'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// receiver: random stall per beat, quiet stretches, one long hold-off
	initial begin
		int n, beats;
		out_stall = 1'b1;
		beats     = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (beats == HOLD_BEAT) begin
				out_stall = 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
			end else begin
				n = ((beats / 80) % 4 == 1) ? 0 : $urandom_range(0, 5);
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			beats++;
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else if (arst_n)
				idle_cycles++;
			if (idle_cycles >= WD_LIMIT) begin
				$display("timeout after %0d idle cycles", WD_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		in_valid  = 1'b0;
		delta_w   = '0;
		delta_x   = '0;
		delta_y   = '0;
		delta_z   = '0;
		sent      = 0;
		arst_n    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: identity, zero product, field extremes, tiny and huge norms
		send_delta(16'sd16384, 0, 0, 0);
		send_delta(0, 0, 0, 0);
		send_delta(16'sd1, 0, 0, 0);
		send_delta(0, 16'sd1, 0, 0);
		send_delta(0, 0, 16'sd1, 0);
		send_delta(0, 0, 0, 16'sd1);
		send_delta(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_delta(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_delta(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_delta(16'sh8000, 0, 0, 0);
		send_delta(0, 16'sh8000, 0, 0);
		send_delta(0, 0, 16'sh7fff, 0);
		send_delta(0, 0, 0, 16'sh8000);
		send_delta(0, 0, 0, 0);
		send_delta(16'sd11585, 16'sd11585, 0, 0);
		send_delta(16'sd11585, 0, 16'sd11585, 0);
		send_delta(16'sd11585, 0, 0, -16'sd11585);
		send_delta(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
		send_delta(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
		send_delta(16'sd16384, 0, 0, 0);

		// random: mostly small rotations, some arbitrary deltas and zeros
		for (int k = 0; k < N_RANDOM; k++) begin
			kind = $urandom_range(0, 19);
			if (kind < 11)
				send_delta(16'sd16384 + small_val(600), small_val(900),
					small_val(900), small_val(900));
			else if (kind < 18)
				send_delta(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else if (kind == 18)
				send_delta(0, 0, 0, 0);
			else
				send_delta(small_val(3), small_val(3), small_val(3), small_val(3));
		end
		in_valid  = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("sent %0d delta beats, %0d of them with a zero product,", sent, zero_seen);
		$display("with random gaps, random output stalls and one long hold-off");
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== quaternion_orientation_integrator_unit.f =====
+incdir+design
design/qoi_pkg.sv
design/qoi_mul.sv
design/qoi_sqdiv.sv
design/quaternion_orientation_integrator_unit.sv
dv/qoi_checker.sv
dv/tb.sv
